// ===== hdl/lmps_pkg.sv =====
// ----------------------------------------------------------------------------
// lmps_pkg
// Types, codes and reset values shared by the lamp mode pulse sequencer.
// ----------------------------------------------------------------------------
package lmps_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_EDGE  = 2'd1,
        FUNC_MODE  = 2'd2,
        FUNC_ONOFF = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        LS_UNKNOWN  = 2'd0,
        LS_OFF      = 2'd1,
        LS_CONSTANT = 2'd2,
        LS_FLASHING = 2'd3
    } lamp_t;

    localparam logic [1:0] MODE_NONE      = 2'd0;
    localparam logic [1:0] MODE_CONSTANT  = 2'd1;
    localparam logic [1:0] MODE_FLASHING  = 2'd2;
    localparam logic [1:0] MODE_ALTERNATE = 2'd3;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_HIGH       = 7'b0000010,
        PH_GAP        = 7'b0000100,
        PH_FIRST_HIGH = 7'b0001000,
        PH_FIRST_GAP  = 7'b0010000,
        PH_SETTLE     = 7'b0100000,
        PH_TOGGLE     = 7'b1000000
    } phase_t;

    // register index, byte address is four times this
    typedef enum logic [2:0] {
        REG_CHECK_INTERVAL = 3'd0,
        REG_CONST_THRESH   = 3'd1,
        REG_PULSE_HIGH     = 3'd2,
        REG_PULSE_GAP      = 3'd3,
        REG_SETTLE         = 3'd4,
        REG_TOGGLE         = 3'd5
    } reg_idx_t;

    localparam logic [15:0] CHECK_INTERVAL_RST = 16'd450;
    localparam logic [7:0]  CONST_THRESH_RST   = 8'd10;
    localparam logic [15:0] PULSE_HIGH_RST     = 16'd50;
    localparam logic [15:0] PULSE_GAP_RST      = 16'd1000;
    localparam logic [15:0] SETTLE_RST         = 16'd1000;
    localparam logic [15:0] TOGGLE_RST         = 16'd1000;

    localparam logic [7:0] EDGE_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] check_interval;
        logic [7:0]  constant_threshold;
        logic [15:0] pulse_high_time;
        logic [15:0] pulse_gap_time;
        logic [15:0] settle_time;
        logic [15:0] toggle_time;
    } cfg_t;

    typedef struct packed {
        logic  control_pin;
        lamp_t lamp_state;
        logic  state_changed;
        logic  busy_res;
    } res_t;

endpackage

// ===== hdl/lmps_core.sv =====
// ----------------------------------------------------------------------------
// lmps_core
// Lamp classification and pulse sequencing state; one item per cycle.
// ----------------------------------------------------------------------------
module lmps_core import lmps_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  func_t      func,
    input  logic [1:0] requested_mode,
    input  logic       on_off_request,
    input  cfg_t       cfg,
    output res_t       res
);

    lamp_t       lamp_reg, lamp_next;
    lamp_t       prev_reg, prev_next;
    logic [7:0]  edge_reg, edge_next;
    logic [15:0] win_reg, win_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] ptimer_reg, ptimer_next;
    logic [1:0]  pulses_reg, pulses_next;
    logic [1:0]  target_reg, target_next;

    logic [15:0] win_inc;
    logic [15:0] ptimer_inc;
    logic [15:0] phase_len;
    logic        window_end;
    logic        phase_done;
    lamp_t       cls;
    lamp_t       lamp_now;
    logic [1:0]  settle_pulses;
    logic [1:0]  pulses_dec;
    logic        changed;

    assign win_inc    = win_reg + 16'd1;
    assign ptimer_inc = ptimer_reg + 16'd1;
    assign pulses_dec = pulses_reg - 2'd1;
    assign window_end = (win_inc >= cfg.check_interval);

    always_comb begin
        priority if (edge_reg == 8'd0) begin
            cls = LS_OFF;
        end else if (edge_reg >= cfg.constant_threshold) begin
            cls = LS_CONSTANT;
        end else begin
            cls = LS_FLASHING;
        end
    end

    // classification lands before the phase timer looks at it
    assign lamp_now = window_end ? cls : lamp_reg;

    always_comb begin
        unique case (phase_reg)
            PH_HIGH, PH_FIRST_HIGH: phase_len = cfg.pulse_high_time;
            PH_GAP, PH_FIRST_GAP:   phase_len = cfg.pulse_gap_time;
            PH_SETTLE:              phase_len = cfg.settle_time;
            PH_TOGGLE:              phase_len = cfg.toggle_time;
            default:                phase_len = 16'd0;
        endcase
    end

    assign phase_done = (ptimer_inc >= phase_len);

    always_comb begin
        unique case (target_reg)
            MODE_CONSTANT:  settle_pulses = (lamp_now == LS_CONSTANT) ? 2'd0 : 2'd1;
            MODE_ALTERNATE: settle_pulses = (lamp_now == LS_CONSTANT) ? 2'd1 : 2'd2;
            MODE_FLASHING:  settle_pulses = (lamp_now == LS_CONSTANT) ? 2'd2 : 2'd3;
            default:        settle_pulses = 2'd0;
        endcase
    end

    always_comb begin
        lamp_next   = lamp_reg;
        prev_next   = prev_reg;
        edge_next   = edge_reg;
        win_next    = win_reg;
        phase_next  = phase_reg;
        ptimer_next = ptimer_reg;
        pulses_next = pulses_reg;
        target_next = target_reg;
        changed     = 1'b0;
        if (item_valid) begin
            unique case (func)
                FUNC_TICK: begin
                    win_next = window_end ? 16'd0 : win_inc;
                    if (window_end) begin
                        lamp_next = cls;
                        prev_next = cls;
                        changed   = (cls != prev_reg);
                        edge_next = 8'd0;
                    end
                    if (phase_reg != PH_IDLE) begin
                        ptimer_next = ptimer_inc;
                        if (phase_done) begin
                            ptimer_next = 16'd0;
                            unique case (phase_reg)
                                PH_HIGH:       phase_next = PH_GAP;
                                PH_FIRST_HIGH: phase_next = PH_FIRST_GAP;
                                PH_FIRST_GAP:  phase_next = PH_SETTLE;
                                PH_GAP: begin
                                    pulses_next = pulses_dec;
                                    if (pulses_dec != 2'd0) begin
                                        phase_next = PH_HIGH;
                                    end else begin
                                        phase_next  = PH_IDLE;
                                        target_next = MODE_NONE;
                                    end
                                end
                                PH_SETTLE: begin
                                    pulses_next = settle_pulses;
                                    if (settle_pulses != 2'd0) begin
                                        phase_next = PH_HIGH;
                                    end else begin
                                        phase_next  = PH_IDLE;
                                        target_next = MODE_NONE;
                                    end
                                end
                                default: begin
                                    phase_next  = PH_IDLE;
                                    pulses_next = 2'd0;
                                    target_next = MODE_NONE;
                                end
                            endcase
                        end
                    end
                end
                FUNC_EDGE: begin
                    if (edge_reg != EDGE_MAX) begin
                        edge_next = edge_reg + 8'd1;
                    end
                end
                FUNC_MODE: begin
                    if (phase_reg == PH_IDLE && requested_mode != MODE_NONE
                            && lamp_reg != LS_OFF) begin
                        ptimer_next = 16'd0;
                        if (lamp_reg == LS_CONSTANT) begin
                            priority if (requested_mode == MODE_ALTERNATE) begin
                                phase_next  = PH_HIGH;
                                pulses_next = 2'd1;
                                target_next = requested_mode;
                            end else if (requested_mode == MODE_FLASHING) begin
                                phase_next  = PH_HIGH;
                                pulses_next = 2'd2;
                                target_next = requested_mode;
                            end else begin
                                phase_next  = PH_IDLE;
                                pulses_next = 2'd0;
                                target_next = MODE_NONE;
                            end
                        end else begin
                            phase_next  = PH_FIRST_HIGH;
                            pulses_next = 2'd0;
                            target_next = requested_mode;
                        end
                    end
                end
                default: begin
                    // toggle only when the request disagrees with the lamp
                    if (phase_reg == PH_IDLE
                            && (on_off_request == (lamp_reg == LS_OFF))) begin
                        phase_next  = PH_TOGGLE;
                        ptimer_next = 16'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lamp_reg   <= LS_UNKNOWN;
            prev_reg   <= LS_UNKNOWN;
            edge_reg   <= 8'd0;
            win_reg    <= 16'd0;
            phase_reg  <= PH_IDLE;
            ptimer_reg <= 16'd0;
            pulses_reg <= 2'd0;
            target_reg <= MODE_NONE;
        end else begin
            lamp_reg   <= lamp_next;
            prev_reg   <= prev_next;
            edge_reg   <= edge_next;
            win_reg    <= win_next;
            phase_reg  <= phase_next;
            ptimer_reg <= ptimer_next;
            pulses_reg <= pulses_next;
            target_reg <= target_next;
        end
    end

    assign res.control_pin   = (phase_next == PH_HIGH) || (phase_next == PH_FIRST_HIGH)
                               || (phase_next == PH_TOGGLE);
    assign res.lamp_state    = lamp_next;
    assign res.state_changed = changed;
    assign res.busy_res      = (phase_next != PH_IDLE);

endmodule

// ===== hdl/lamp_mode_pulse_sequencer.sv =====
// ----------------------------------------------------------------------------
// lamp_mode_pulse_sequencer
// Classifies a lamp from its drive edges and pulses its control pin to step
// through modes; APB register file, stream in, registered stream out.
// ----------------------------------------------------------------------------
// result: registered in the output register, or in the skid entry under stall
// throughput: one item per cycle while the skid entry is empty; state update is
//   a single pass of compare and count logic, results go to an output register backed by one skid entry
// reset: aresetn synchronous active low, clears lamp and sequencer state,
//   empties the output stage and loads register defaults
module lamp_mode_pulse_sequencer import lmps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] requested_mode, [2] on_off_request
    input  logic [1:0]  s_axis_tuser,   // [1:0] func

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] control_pin, [2:1] lamp_state,
                                        // [3] state_changed, [4] busy_res

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;

    res_t     core_res;
    res_t     out_reg;
    res_t     skid_reg;
    logic     out_valid_reg;
    logic     skid_valid_reg;
    logic     in_accept;
    logic     out_pop;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.check_interval     <= CHECK_INTERVAL_RST;
            cfg_reg.constant_threshold <= CONST_THRESH_RST;
            cfg_reg.pulse_high_time    <= PULSE_HIGH_RST;
            cfg_reg.pulse_gap_time     <= PULSE_GAP_RST;
            cfg_reg.settle_time        <= SETTLE_RST;
            cfg_reg.toggle_time        <= TOGGLE_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_CHECK_INTERVAL: cfg_reg.check_interval     <= pwdata[15:0];
                REG_CONST_THRESH:   cfg_reg.constant_threshold <= pwdata[7:0];
                REG_PULSE_HIGH:     cfg_reg.pulse_high_time    <= pwdata[15:0];
                REG_PULSE_GAP:      cfg_reg.pulse_gap_time     <= pwdata[15:0];
                REG_SETTLE:         cfg_reg.settle_time        <= pwdata[15:0];
                REG_TOGGLE:         cfg_reg.toggle_time        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CHECK_INTERVAL: prdata = {16'd0, cfg_reg.check_interval};
            REG_CONST_THRESH:   prdata = {24'd0, cfg_reg.constant_threshold};
            REG_PULSE_HIGH:     prdata = {16'd0, cfg_reg.pulse_high_time};
            REG_PULSE_GAP:      prdata = {16'd0, cfg_reg.pulse_gap_time};
            REG_SETTLE:         prdata = {16'd0, cfg_reg.settle_time};
            REG_TOGGLE:         prdata = {16'd0, cfg_reg.toggle_time};
            default:            prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = out_valid_reg && m_axis_tready;

    lmps_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (in_accept),
        .func           (func_t'(s_axis_tuser)),
        .requested_mode (s_axis_tdata[1:0]),
        .on_off_request (s_axis_tdata[2]),
        .cfg            (cfg_reg),
        .res            (core_res)
    );

    // output register with one skid entry so one more item can be taken under stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (in_accept) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_pop) begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_reg <= core_res;
            end else begin
                skid_reg <= core_res;
            end
        end else if (out_pop && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_reg.busy_res, out_reg.state_changed,
                            out_reg.lamp_state, out_reg.control_pin};

    // skid entry is only ever filled behind a held output
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // pin high only while a sequence runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[4])
        else $error("control pin high while sequencer idle");

    // a change is only reported from a window end, never to unknown
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2:1] != LS_UNKNOWN))
        else $error("state change reported to unknown lamp state");

    // with a free output side the input is never held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg) |-> s_axis_tready)
        else $error("input stalled with empty output stage");

endmodule
